// ===== src/f2p_pkg.sv =====
// Package for the float-to-PCM16 converter: beat types and fixed constants.
// No dependencies; the converter and its testbench import it.
`timescale 1ns / 1ps

package f2p_pkg;

	localparam logic [31:0] ABS_MASK    = 32'h7FFF_FFFF;
	localparam logic [30:0] INF_BITS    = 31'h7F80_0000;
	localparam logic [30:0] ONE_BITS    = 31'h3F80_0000;
	localparam logic [14:0] SCALE_INT   = 15'd32767;
	localparam logic [15:0] PCM_MAX     = 16'sd32767;
	localparam logic [15:0] PCM_MIN     = -16'sd32767;
	localparam logic [8:0]  EXP_OFFSET  = 9'd150;
	localparam int          SH_MIN      = 8;
	localparam int          SH_MAX      = 25;

	typedef struct packed {
		logic [31:0] sample_bits;
		logic        end_of_block;
	} f2p_in_beat_t;

	typedef struct packed {
		logic signed [15:0] pcm_value;
		logic               end_of_block_out;
	} f2p_out_beat_t;

endpackage

// ===== src/f2p_in_if.sv =====
// Input channel of the converter: valid/ready plus one float sample beat.
// Depends on nothing but the handshake convention.
`timescale 1ns / 1ps

interface f2p_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] sample_bits;
	logic        end_of_block;

	modport source (output valid, sample_bits, end_of_block, input ready);
	modport sink   (input valid, sample_bits, end_of_block, output ready);
endinterface

// ===== src/f2p_out_if.sv =====
// Output channel of the converter: valid/ready plus one PCM beat.
// Depends on nothing but the handshake convention.
`timescale 1ns / 1ps

interface f2p_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] pcm_value;
	logic               end_of_block_out;

	modport source (output valid, pcm_value, end_of_block_out, input ready);
	modport sink   (input valid, pcm_value, end_of_block_out, output ready);
endinterface

// ===== src/float_to_pcm16_converter.sv =====
// Top level of the float-to-PCM16 converter, a three-stage pipeline.
// Depends on f2p_pkg, f2p_in_if and f2p_out_if.
//
//   channel  | dir | beat contents
//   in_ch    | in  | sample_bits[31:0], end_of_block
//   out_ch   | out | pcm_value[15:0] signed, end_of_block_out
//
// One sample per cycle while out_ch is not stalled; a result passes the stage 1,
// stage 2 and stage 3 registers before it sits on out_ch.
// Stage 1 scales the mantissa, stage 2 rounds to single precision, stage 3
// rounds to an integer and saturates; the last stage is the output register.
// Reset clears the stage valid bits only.
// A stall on out_ch freezes every stage together; the input accepts whenever the
// output register is empty or being emptied.
`timescale 1ns / 1ps

module float_to_pcm16_converter
	import f2p_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	f2p_in_if.sink     in_ch,
	f2p_out_if.source  out_ch
);

	logic adv;

	// Stage 1 registers
	logic        v_s1;
	logic        sat_s1;
	logic        sat_pos_s1;
	logic        neg_s1;
	logic        zero_s1;
	logic [7:0]  bexp_s1;
	logic [38:0] prod_s1;
	logic        eob_s1;

	// Stage 2 registers
	logic        v_s2;
	logic        sat_s2;
	logic        sat_pos_s2;
	logic        neg_s2;
	logic        zero_s2;
	logic [4:0]  sh_s2;
	logic [24:0] q_s2;
	logic        eob_s2;

	// Stage 3 (output) registers
	logic               v_s3;
	logic signed [15:0] pcm_s3;
	logic               eob_s3;

	assign adv         = !v_s3 || out_ch.ready;
	assign in_ch.ready = adv;

	// ---- stage 1 logic
	logic [30:0] absb;
	logic [23:0] mant;
	assign absb = in_ch.sample_bits[30:0];
	assign mant = {1'b1, in_ch.sample_bits[22:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// NaN saturates positive; any other value above one keeps its sign.
			sat_s1     <= (absb > ONE_BITS);
			sat_pos_s1 <= (absb > INF_BITS) || !in_ch.sample_bits[31];
			neg_s1     <= in_ch.sample_bits[31];
			zero_s1    <= (in_ch.sample_bits[30:23] == 8'd0);
			bexp_s1    <= in_ch.sample_bits[30:23];
			prod_s1    <= 39'(mant) * 39'(SCALE_INT);
			eob_s1     <= in_ch.end_of_block;
		end
	end

	// ---- stage 2 logic: round the product to 24 significant bits
	logic        top;
	logic [24:0] q_trunc;
	logic        guard;
	logic        sticky;
	logic        rnd_up;
	logic [8:0]  sh_full;

	always_comb begin
		top = prod_s1[38];
		if (top) begin
			q_trunc = {1'b0, prod_s1[38:15]};
			guard   = prod_s1[14];
			sticky  = |prod_s1[13:0];
		end else begin
			q_trunc = {1'b0, prod_s1[37:14]};
			guard   = prod_s1[13];
			sticky  = |prod_s1[12:0];
		end
		rnd_up  = guard && (sticky || q_trunc[0]);
		sh_full = EXP_OFFSET - {1'b0, bexp_s1} - (top ? 9'd15 : 9'd14);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sat_s2     <= sat_s1;
			sat_pos_s2 <= sat_pos_s1;
			neg_s2     <= neg_s1;
			// Shifts beyond the widest useful one always round to zero.
			zero_s2    <= zero_s1 || (sh_full > 9'(SH_MAX));
			sh_s2      <= sh_full[4:0];
			q_s2       <= q_trunc + 25'(rnd_up);
			eob_s2     <= eob_s1;
		end
	end

	// ---- stage 3 logic: round half away from zero, saturate, apply sign
	logic [25:0] biased;
	logic [25:0] shifted;
	logic [14:0] mag;
	logic signed [15:0] pcm_next;

	always_comb begin
		biased  = {1'b0, q_s2} + (26'd1 << (sh_s2 - 5'd1));
		shifted = biased >> sh_s2;
		if (zero_s2) begin
			mag = 15'd0;
		end else if (shifted > 26'(SCALE_INT)) begin
			mag = SCALE_INT;
		end else begin
			mag = shifted[14:0];
		end
		if (sat_s2) begin
			pcm_next = sat_pos_s2 ? PCM_MAX : PCM_MIN;
		end else if (neg_s2) begin
			pcm_next = -$signed({1'b0, mag});
		end else begin
			pcm_next = $signed({1'b0, mag});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pcm_s3 <= pcm_next;
			eob_s3 <= eob_s2;
		end
	end

	assign out_ch.valid            = v_s3;
	assign out_ch.pcm_value        = pcm_s3;
	assign out_ch.end_of_block_out = eob_s3;

	// The symmetric range never yields the most negative code.
	a_no_min_code: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> (pcm_s3 != 16'sh8000))
		else $error("PCM output holds the most negative code");

	// A stall freezes an item held in the middle stage.
	a_s2_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && !adv) |=> (v_s2 && $stable(q_s2)))
		else $error("Middle stage lost or changed its item during a stall");

	// A normal-range sample never needs an integer rounding shift below SH_MIN.
	a_shift_range: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && !zero_s2 && !sat_s2) |-> (sh_s2 >= 5'(SH_MIN)))
		else $error("Integer rounding shift below its minimum");

endmodule

// ===== test/float_to_pcm16_converter_tb.sv =====
// Testbench for the float-to-PCM16 converter: directed and random samples are
// pushed through the valid/ready channels, and each beat is checked against a predictor.
// Depends on f2p_pkg, f2p_in_if, f2p_out_if and float_to_pcm16_converter.
`timescale 1ns / 1ps

module float_to_pcm16_converter_tb;
	import f2p_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 10;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	f2p_in_if  in_ch ();
	f2p_out_if out_ch ();

	float_to_pcm16_converter dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch.sink),
		.out_ch (out_ch.source)
	);

	always #6 clk = ~clk;

	f2p_out_beat_t pending_pcm[$];
	int  error_count = 0;
	int  idle_cycles = 0;
	bit  sink_idling = 1'b1;  // The sink idles at random only while this is set.
	bit  src_idling  = 1'b1;  // The source idles at random only while this is set.
	int  hold_off = 0;        // Cycles for which the sink must keep ready low.

	initial begin
		in_ch.valid        = 1'b0;
		in_ch.sample_bits  = '0;
		in_ch.end_of_block = 1'b0;
		out_ch.ready       = 1'b0;
	end

	// Scale by 32767, round to single precision, then round halves away from zero.
	function automatic logic signed [15:0] scale_magnitude(input logic [30:0] absb);
		logic [7:0]  bexp;
		logic [63:0] prod, rem, half, q, r;
		int          expo, len, s, sh;
		begin
			bexp = absb[30:23];
			if (bexp == 0) return 16'sd0;
			prod = {40'd0, 1'b1, absb[22:0]} * 64'd32767;
			expo = int'(bexp) - 150;
			len = 0;
			for (int i = 0; i < 64; i++) if (prod[i]) len = i + 1;
			if (len > 24) begin
				s = len - 24;
				q = prod >> s;
				rem = prod & ((64'd1 << s) - 1);
				half = 64'd1 << (s - 1);
				if (rem > half || (rem == half && q[0])) q = q + 1;
				prod = q;
				expo = expo + s;
			end
			if (expo >= 0) begin
				if (expo > 15) return 16'sd32767;
				prod = prod << expo;
				return (prod > 32767) ? 16'sd32767 : 16'(prod);
			end
			sh = -expo;
			if (sh > 40) return 16'sd0;
			r = (prod + (64'd1 << (sh - 1))) >> sh;
			return (r > 32767) ? 16'sd32767 : 16'(r);
		end
	endfunction

	function automatic f2p_out_beat_t predict_pcm(input logic [31:0] bits, input logic eob);
		f2p_out_beat_t res;
		logic [30:0]   absb;
		logic signed [15:0] m;
		begin
			absb = bits[30:0];
			res.end_of_block_out = eob;
			if (absb > INF_BITS) res.pcm_value = 16'sd32767;
			else if (absb > ONE_BITS) res.pcm_value = bits[31] ? -16'sd32767 : 16'sd32767;
			else begin
				m = scale_magnitude(absb);
				res.pcm_value = bits[31] ? -m : m;
			end
			return res;
		end
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $time, msg);
		error_count++;
	endtask

	// Valid stays high after a beat is taken so that back-to-back beats need
	// only one assignment to it per clock edge.
	task automatic send_sample(input logic [31:0] bits, input logic eob);
		while (src_idling && $urandom_range(99) < 25) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid        <= 1'b1;
		in_ch.sample_bits  <= bits;
		in_ch.end_of_block <= eob;
		do @(posedge clk); while (!in_ch.ready);
		pending_pcm.push_back(predict_pcm(bits, eob));
	endtask

	// Sink side: random or held-off ready, and the check of every accepted beat.
	always @(posedge clk) begin
		f2p_out_beat_t want;
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				if (pending_pcm.size() == 0)
					report_mismatch($sformatf("unexpected beat pcm=%0d", out_ch.pcm_value));
				else begin
					want = pending_pcm.pop_front();
					if (out_ch.pcm_value !== want.pcm_value)
						report_mismatch($sformatf("pcm_value %0d, expected %0d",
							out_ch.pcm_value, want.pcm_value));
					if (out_ch.end_of_block_out !== want.end_of_block_out)
						report_mismatch($sformatf("end_of_block_out %b, expected %b",
							out_ch.end_of_block_out, want.end_of_block_out));
				end
			end
			if (hold_off > 0) begin
				hold_off <= hold_off - 1;
				out_ch.ready <= 1'b0;
			end else
				out_ch.ready <= !(sink_idling && $urandom_range(99) < 25);
		end
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Watchdog expired at %0t", $time);
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic logic [31:0] random_sample();
		logic [31:0] bits;
		begin
			bits = $urandom;
			case ($urandom_range(9))
				0, 1, 2, 3, 4: bits[30:23] = 8'(100 + $urandom_range(27)); // exponent 100 to 127, mostly in nominal range
				5: bits[30:0] = $urandom_range(1) ? ONE_BITS : (ONE_BITS + 31'd1);
				6: bits[30:23] = 8'hFF;
				7: bits[30:23] = 8'h00;
				default: ;
			endcase
			return bits;
		end
	endfunction

	task automatic test_directed();
		logic [31:0] vals[] = '{32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'hBF80_0000,
			32'h3F80_0001, 32'hBF80_0001, 32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000,
			32'hFFC0_0000, 32'h7F80_0001, 32'h0000_0001, 32'h807F_FFFF, 32'h3F00_0000,
			32'hBF00_0000, 32'h3800_0000, 32'h3800_4000, 32'hB800_4000, 32'h7F7F_FFFF,
			32'hFFFF_FFFF, 32'h3F7F_FFFF, 32'h3A80_0000};
		foreach (vals[i]) send_sample(vals[i], i[0]);
	endtask

	task automatic test_random(input int count);
		repeat (count) send_sample(random_sample(), $urandom_range(1));
	endtask

	task automatic test_no_idling(input int count);
		src_idling = 1'b0;
		sink_idling = 1'b0;
		test_random(count);
		src_idling = 1'b1;
		sink_idling = 1'b1;
	endtask

	task automatic test_backpressure();
		hold_off = 60;
		src_idling = 1'b0;
		test_random(40);
		src_idling = 1'b1;
	endtask

	initial begin
		int waited;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(800);
		test_no_idling(400);
		test_backpressure();
		test_random(460);
		in_ch.valid <= 1'b0;
		waited = 0;
		while (pending_pcm.size() != 0 && waited < WATCHDOG_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0 && pending_pcm.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
